>>> sv/bfsa_pkg.sv
`default_nettype none
package bfsa_pkg;

   localparam int MAX_SLOTS = 32;
   localparam int SLOT_BITS = $clog2(MAX_SLOTS);
   localparam int CNT_BITS  = $clog2(MAX_SLOTS + 1);
   localparam int ADDR_BITS = 16;
   localparam int ID_BITS   = 16;
   localparam int TIME_BITS = 32;

   localparam logic [ADDR_BITS-1:0] MEM_RESET = {ADDR_BITS{1'b1}};

   localparam logic [2:0] ACT_ALLOCATE = 3'd0;
   localparam logic [2:0] ACT_RELEASE  = 3'd1;
   localparam logic [2:0] ACT_COMPACT  = 3'd2;
   localparam logic [2:0] ACT_ADVANCE  = 3'd3;
   localparam logic [2:0] ACT_PROBE    = 3'd4;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_FIT    = 2'd1;
   localparam logic [1:0] STAT_DUPLICATE = 2'd2;
   localparam logic [1:0] STAT_UNKNOWN   = 2'd3;

   typedef struct packed {
      logic [2:0]           action;
      logic [ID_BITS-1:0]   job_id;
      logic [ADDR_BITS-1:0] job_size;
      logic [TIME_BITS-1:0] job_lifetime;
      logic [TIME_BITS-1:0] time_delta;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] base_position;
      logic [ADDR_BITS-1:0] best_hole_size;
      logic                 id_present;
      logic [ADDR_BITS-1:0] free_units;
      logic [5:0]           job_count;
      logic [5:0]           expired_count;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 mark;
      logic [ID_BITS-1:0]   owner;
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] length;
      logic [TIME_BITS-1:0] remaining;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic take_left;
      logic take_new;
      logic take_right;
      logic mark_match;
      logic age;
      logic compact;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_INSERT,
      S_DELETE,
      S_COMPACT,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

>>> sv/bfsa_cell.sv
`default_nettype none
module bfsa_cell (
   input  wire                             clock,
   input  wire                             reset,
   input  bfsa_pkg::cell_ctrl_type         ctrl,
   input  bfsa_pkg::entry_type             left_entry,
   input  bfsa_pkg::entry_type             right_entry,
   input  bfsa_pkg::entry_type             new_entry,
   input  wire [bfsa_pkg::ID_BITS-1:0]     match_id,
   input  wire [bfsa_pkg::TIME_BITS-1:0]   delta,
   output bfsa_pkg::entry_type             entry,
   output logic                            match,
   output logic                            due
);
   import bfsa_pkg::*;

   entry_type            entry_ff, entry_in;
   logic [ADDR_BITS:0]   left_end;

   assign left_end = {1'b0, left_entry.base} + {1'b0, left_entry.length};
   assign match    = entry_ff.valid && (entry_ff.owner == match_id);
   assign due      = entry_ff.valid && (entry_ff.remaining <= delta);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.take_new) begin
         entry_in = new_entry;
      end else if (ctrl.take_left) begin
         entry_in = left_entry;
      end else if (ctrl.take_right) begin
         entry_in = right_entry;
      end else if (ctrl.mark_match) begin
         entry_in.mark = match;
      end else if (ctrl.age) begin
         if (due) begin
            entry_in.mark = 1'b1;
         end else begin
            entry_in.remaining = entry_ff.remaining - delta;
         end
      end else if (ctrl.compact && entry_ff.valid) begin
         // The left neighbour's end settles one cell further each cycle.
         entry_in.base = left_end[ADDR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset || ctrl.clear) begin
         entry_ff.valid <= 1'b0;
         entry_ff.mark  <= 1'b0;
      end
   end

endmodule
`default_nettype wire

>>> sv/best_fit_segment_allocator_top.sv
`default_nettype none
// Channel   Direction  Handshake                     Payload
// req       in         req_valid / req_stall         req_word  (bfsa_pkg::req_type)
// rsp       out        rsp_valid / rsp_stall         rsp_word  (bfsa_pkg::rsp_type)
// csr       in         csr_write_enable              csr_write_data (memory_units)
//
// Jobs sit in a row of 32 cells kept sorted by base, valid cells packed at the low end.
// Allocate and probe make one scan step per cell for the hole search; release and advance
// free one marked job per delete step; compact moves each valid job down to the end of its
// left neighbour. Reset and a csr write clear every job; there is no clearing pass.
// The next word is taken once the previous result is in the output register; a stall on
// rsp holds the finished result and holds back the next one.
module best_fit_segment_allocator_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  bfsa_pkg::req_type                  req_word,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output bfsa_pkg::rsp_type                  rsp_word,
   input  wire                                csr_write_enable,
   input  wire [bfsa_pkg::ADDR_BITS-1:0]      csr_write_data
);
   import bfsa_pkg::*;

   state_type             state_ff, state_in;
   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]   n_ff, n_in;
   logic [ADDR_BITS-1:0]  free_ff, free_in;
   logic [ADDR_BITS-1:0]  mem_ff, mem_in;
   logic [CNT_BITS:0]     scan_k_ff, scan_k_in;
   logic [ADDR_BITS:0]    prev_end_ff, prev_end_in;
   logic                  found_ff, found_in;
   logic [ADDR_BITS-1:0]  best_ff, best_in;
   logic [ADDR_BITS-1:0]  best_pos_ff, best_pos_in;
   logic [CNT_BITS-1:0]   ins_ff, ins_in;
   logic [CNT_BITS-1:0]   exp_ff, exp_in;
   logic [CNT_BITS-1:0]   cyc_ff, cyc_in;
   logic [1:0]            status_ff, status_in;
   logic [ADDR_BITS-1:0]  hole_ff, hole_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;

   entry_type             cell_entry [MAX_SLOTS];
   cell_ctrl_type         cell_ctrl  [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]  match_vec, due_vec, mark_vec, valid_vec;
   entry_type             new_entry, scan_entry;
   logic                  any_match, any_mark;
   logic [SLOT_BITS-1:0]  del_idx;
   logic [ADDR_BITS-1:0]  gap, gap_pos;
   logic [ADDR_BITS:0]    scan_end;

   assign new_entry = '{valid: 1'b1, mark: 1'b0, owner: req_ff.job_id, base: best_pos_ff,
                        length: req_ff.job_size, remaining: req_ff.job_lifetime};

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      entry_type left_e, right_e;
      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_inner_l
         assign left_e = cell_entry[i-1];
      end
      if (i == MAX_SLOTS - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner_r
         assign right_e = cell_entry[i+1];
      end

      always_comb begin
         cell_ctrl[i].clear      = csr_write_enable;
         cell_ctrl[i].take_new   = (state_ff == S_INSERT) && (ins_ff == CNT_BITS'(i));
         cell_ctrl[i].take_left  = (state_ff == S_INSERT) && (ins_ff < CNT_BITS'(i));
         cell_ctrl[i].take_right = (state_ff == S_DELETE) && any_mark
                                   && (del_idx <= SLOT_BITS'(i));
         cell_ctrl[i].mark_match = (state_ff == S_CHECK) && (req_ff.action == ACT_RELEASE);
         cell_ctrl[i].age        = (state_ff == S_CHECK) && (req_ff.action == ACT_ADVANCE);
         cell_ctrl[i].compact    = (state_ff == S_COMPACT);
      end

      bfsa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .left_entry  (left_e),
         .right_entry (right_e),
         .new_entry   (new_entry),
         .match_id    (req_ff.job_id),
         .delta       (req_ff.time_delta),
         .entry       (cell_entry[i]),
         .match       (match_vec[i]),
         .due         (due_vec[i])
      );

      assign mark_vec[i]  = cell_entry[i].mark;
      assign valid_vec[i] = cell_entry[i].valid;
   end

   assign any_match = |match_vec;
   assign any_mark  = |mark_vec;

   always_comb begin
      del_idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (mark_vec[i]) begin
            del_idx = SLOT_BITS'(i);
         end
      end
   end

   // One cell is read per scan step; the hole below it ends at its base.
   assign scan_entry = cell_entry[scan_k_ff[SLOT_BITS-1:0]];
   assign scan_end   = {1'b0, scan_entry.base} + {1'b0, scan_entry.length};

   always_comb begin
      gap_pos = prev_end_ff[ADDR_BITS-1:0];
      if (scan_k_ff < {1'b0, n_ff}) begin
         gap = scan_entry.base - prev_end_ff[ADDR_BITS-1:0];
      end else if ({1'b0, mem_ff} > prev_end_ff) begin
         gap = mem_ff - prev_end_ff[ADDR_BITS-1:0];
      end else begin
         gap = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      n_in         = n_ff;
      free_in      = free_ff;
      mem_in       = mem_ff;
      scan_k_in    = scan_k_ff;
      prev_end_in  = prev_end_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      ins_in       = ins_ff;
      exp_in       = exp_ff;
      cyc_in       = cyc_ff;
      status_in    = status_ff;
      hole_in      = hole_ff;
      base_in      = base_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_word;
               state_in    = S_CHECK;
               scan_k_in   = '0;
               prev_end_in = '0;
               found_in    = 1'b0;
               best_in     = '0;
               best_pos_in = '0;
               ins_in      = '0;
               exp_in      = '0;
               cyc_in      = '0;
               status_in   = STAT_OK;
               hole_in     = '0;
               base_in     = '0;
            end
         end
         S_CHECK: begin
            case (req_ff.action)
               ACT_ALLOCATE: begin
                  if (any_match) begin
                     status_in = STAT_DUPLICATE;
                     state_in  = S_FINISH;
                  end else if (req_ff.job_size == '0) begin
                     status_in = STAT_NO_FIT;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               ACT_RELEASE: begin
                  if (!any_match) begin
                     status_in = STAT_UNKNOWN;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_DELETE;
                  end
               end
               ACT_COMPACT: state_in = S_COMPACT;
               ACT_ADVANCE: state_in = S_DELETE;
               ACT_PROBE: begin
                  if (req_ff.job_size == '0) begin
                     status_in = STAT_NO_FIT;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            if (scan_k_ff <= {1'b0, n_ff}) begin
               // Equal holes: the later one lies higher, so it wins.
               if (gap != '0 && gap >= req_ff.job_size && (!found_ff || gap <= best_ff)) begin
                  found_in    = 1'b1;
                  best_in     = gap;
                  best_pos_in = gap_pos;
                  ins_in      = scan_k_ff[CNT_BITS-1:0];
               end
               if (scan_k_ff < {1'b0, n_ff}) begin
                  prev_end_in = scan_end;
               end
               scan_k_in = scan_k_ff + 1'b1;
            end else if (!found_ff) begin
               status_in = STAT_NO_FIT;
               state_in  = S_FINISH;
            end else begin
               hole_in = best_ff;
               if (req_ff.action != ACT_ALLOCATE) begin
                  state_in = S_FINISH;
               end else if (n_ff == CNT_BITS'(MAX_SLOTS)) begin
                  status_in = STAT_NO_FIT;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_INSERT: begin
            n_in     = n_ff + 1'b1;
            free_in  = free_ff - req_ff.job_size;
            base_in  = best_pos_ff;
            state_in = S_FINISH;
         end
         S_DELETE: begin
            if (any_mark) begin
               free_in = free_ff + cell_entry[del_idx].length;
               n_in    = n_ff - 1'b1;
               if (req_ff.action == ACT_ADVANCE) begin
                  exp_in = exp_ff + 1'b1;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_COMPACT: begin
            cyc_in = cyc_ff + 1'b1;
            if (cyc_ff == CNT_BITS'(MAX_SLOTS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status         = status_ff;
               rsp_in.base_position  = base_ff;
               rsp_in.best_hole_size = hole_ff;
               rsp_in.id_present     = any_match;
               rsp_in.free_units     = free_ff;
               rsp_in.job_count      = 6'(n_ff);
               rsp_in.expired_count  = 6'(exp_ff);
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write_enable) begin
         mem_in  = csr_write_data;
         free_in = csr_write_data;
         n_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      scan_k_ff   <= scan_k_in;
      prev_end_ff <= prev_end_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_pos_ff <= best_pos_in;
      ins_ff      <= ins_in;
      exp_ff      <= exp_in;
      cyc_ff      <= cyc_in;
      status_ff   <= status_in;
      hole_ff     <= hole_in;
      base_ff     <= base_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         free_ff      <= MEM_RESET;
         mem_ff       <= MEM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         free_ff      <= free_in;
         mem_ff       <= mem_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_packed_count : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(n_ff))
      else $error("resident count disagrees with valid cells");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_BITS'(MAX_SLOTS))
      else $error("resident count beyond table size");

   a_insert_room : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (n_ff < CNT_BITS'(MAX_SLOTS)) && (ins_ff <= n_ff))
      else $error("insert without a free cell");

   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_k_ff <= {1'b0, n_ff} + 1'b1))
      else $error("scan ran past the resident jobs");

endmodule
`default_nettype wire
